>>> sv/text_stream_visualizer_assert.svh
// Assertion macros for the checker file of the text stream visualiser.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TEXT_STREAM_VISUALIZER_ASSERT_SVH
`define TEXT_STREAM_VISUALIZER_ASSERT_SVH

// same-cycle implication
`define TSV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsv assertion failed");

// next-cycle implication
`define TSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsv assertion failed");

`endif

>>> sv/tsv_pkg.sv
// Package for the text stream visualiser: sizes, codes, character constants
// and the payload and descriptor types. No dependencies.
package tsv_pkg;

  localparam int NumberDigits = 6;
  localparam int BcdW         = 4 * NumberDigits;
  // byte index within one run; the run is at most NumberDigits + 5 long
  localparam int IdxW         = $clog2(NumberDigits + 6);

  // descriptor queue; depth must be a power of two
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHOW_NONPRINTING = 3'd4;
  localparam int CfgDataW = 2;

  // numbering modes (code 3 numbers nothing)
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONEMPTY = 2'd2;

  // characters
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [3:0] ChDigitHi = 4'h3;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChI      = 8'h49;
  localparam logic [7:0] ChM      = 8'h4D;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChMetaLo = 8'h80;
  localparam logic [7:0] ChMetaHi = 8'h9F;
  localparam logic [7:0] ChCtlHi  = 8'h1F;
  localparam logic [7:0] ChShift  = 8'h40;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
  } cfg_t;

  // prefix emitted ahead of the final character
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_CARET,
    PRE_DOLLAR,
    PRE_META
  } pre_e;

  // one queued run: optional line number, prefix, final character
  typedef struct packed {
    logic            num;
    logic [BcdW-1:0] bcd;
    pre_e            pre;
    logic [7:0]      ch;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } push_t;

endpackage

>>> sv/tsv_front.sv
// Front end: accepts bytes, keeps the per-file line state and classifies each
// byte into a run descriptor. Depends on tsv_pkg.
module tsv_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsv_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  tsv_pkg::in_t   in_data_i,
  input  logic           q_full_i,
  output logic           in_stall_o,
  output tsv_pkg::push_t push_o
);

  logic [tsv_pkg::BcdW-1:0] bcd_q, bcd_d;
  logic                     after_nl_q, after_nl_d;
  logic [1:0]               nl_run_q, nl_run_d;

  logic [tsv_pkg::BcdW-1:0] eff_bcd, next_bcd;
  logic                     eff_after;
  logic [1:0]               eff_run;
  logic                     accept, is_nl, squeeze, do_num;
  logic [7:0]               c;
  tsv_pkg::pre_e            pre;
  logic [7:0]               ch;

  // saturating BCD increment
  function automatic logic [tsv_pkg::BcdW-1:0] bcd_inc(input logic [tsv_pkg::BcdW-1:0] v);
    logic [tsv_pkg::BcdW-1:0] r;
    logic                     carry;
    logic                     full;
    r     = v;
    carry = 1'b1;
    full  = 1'b1;
    for (int i = 0; i < tsv_pkg::NumberDigits; i++) begin
      if (v[4*i +: 4] != 4'd9) full = 1'b0;
    end
    for (int i = 0; i < tsv_pkg::NumberDigits; i++) begin
      if (carry) begin
        if (v[4*i +: 4] >= 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (full) r = v;
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = in_data_i.in_byte;
  assign is_nl      = (c == tsv_pkg::ChNl);

  // start of file clears the line state before the byte is looked at
  assign eff_bcd   = in_data_i.start_of_file ? '0 : bcd_q;
  assign eff_after = in_data_i.start_of_file | after_nl_q;
  assign eff_run   = in_data_i.start_of_file ? 2'd0 : nl_run_q;

  assign squeeze = cfg_i.squeeze_blank && is_nl && (eff_run == 2'd2);
  assign do_num  = eff_after && ((cfg_i.number_mode == tsv_pkg::NUM_ALL) ||
                   ((cfg_i.number_mode == tsv_pkg::NUM_NONEMPTY) && !is_nl));
  assign next_bcd = do_num ? bcd_inc(eff_bcd) : eff_bcd;

  always_comb begin
    pre = tsv_pkg::PRE_NONE;
    ch  = c;
    if (cfg_i.show_tabs && (c == tsv_pkg::ChTab)) begin
      pre = tsv_pkg::PRE_CARET;
      ch  = tsv_pkg::ChI;
    end else if (is_nl) begin
      if (cfg_i.show_ends) pre = tsv_pkg::PRE_DOLLAR;
    end else if (cfg_i.show_nonprinting && (c != tsv_pkg::ChTab)) begin
      if ((c >= tsv_pkg::ChMetaLo) && (c <= tsv_pkg::ChMetaHi)) begin
        pre = tsv_pkg::PRE_META;
        ch  = c - tsv_pkg::ChShift;
      end else if (c <= tsv_pkg::ChCtlHi) begin
        pre = tsv_pkg::PRE_CARET;
        ch  = c + tsv_pkg::ChShift;
      end else if (c == tsv_pkg::ChDel) begin
        pre = tsv_pkg::PRE_CARET;
        ch  = tsv_pkg::ChQuest;
      end
    end
  end

  assign push_o.push      = accept && !squeeze;
  assign push_o.desc.num  = do_num;
  assign push_o.desc.bcd  = next_bcd;
  assign push_o.desc.pre  = pre;
  assign push_o.desc.ch   = ch;

  always_comb begin
    bcd_d      = bcd_q;
    after_nl_d = after_nl_q;
    nl_run_d   = nl_run_q;
    if (accept) begin
      if (squeeze) begin
        // dropped newline: only the file clear takes effect
        bcd_d      = eff_bcd;
        after_nl_d = eff_after;
        nl_run_d   = eff_run;
      end else begin
        bcd_d      = next_bcd;
        after_nl_d = is_nl;
        nl_run_d   = !is_nl ? 2'd0 : ((eff_run == 2'd3) ? 2'd3 : eff_run + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q      <= '0;
      after_nl_q <= 1'b1;
      nl_run_q   <= 2'd0;
    end else begin
      bcd_q      <= bcd_d;
      after_nl_q <= after_nl_d;
      nl_run_q   <= nl_run_d;
    end
  end

endmodule

>>> sv/tsv_queue.sv
// Short descriptor queue between front and back end.
// Depends on tsv_pkg.
module tsv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsv_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output tsv_pkg::desc_t head_o
);

  tsv_pkg::desc_t mem_q [tsv_pkg::QDepth];
  logic [tsv_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tsv_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                      do_push, do_pop;

  assign full_o  = (cnt_q == tsv_pkg::QCntW'(tsv_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.desc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> sv/tsv_back.sv
// Back end: walks the head descriptor one output byte per transaction.
// Depends on tsv_pkg.
module tsv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tsv_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tsv_pkg::out_t  out_data_o
);

  localparam int Nd = tsv_pkg::NumberDigits;

  logic [tsv_pkg::IdxW-1:0] idx_q, idx_d;
  logic [tsv_pkg::IdxW-1:0] n_num, pre_len, k;
  logic [Nd-1:0]            blank;
  logic                     lead, in_num, last;
  logic [7:0]               byte_sel;

  // leading zeros print as spaces, the units digit always prints
  always_comb begin
    lead = 1'b1;
    for (int i = Nd - 1; i >= 0; i--) begin
      blank[i] = lead && (head_i.bcd[4*i +: 4] == 4'd0) && (i > 0);
      if (head_i.bcd[4*i +: 4] != 4'd0) lead = 1'b0;
    end
  end

  always_comb begin
    case (head_i.pre)
      tsv_pkg::PRE_NONE:   pre_len = tsv_pkg::IdxW'(0);
      tsv_pkg::PRE_META:   pre_len = tsv_pkg::IdxW'(3);
      default:             pre_len = tsv_pkg::IdxW'(1);
    endcase
  end

  assign n_num  = head_i.num ? tsv_pkg::IdxW'(Nd + 1) : '0;
  assign in_num = head_i.num && (idx_q <= tsv_pkg::IdxW'(Nd));
  assign k      = idx_q - n_num;
  assign last   = !in_num && (k == pre_len);

  always_comb begin
    byte_sel = head_i.ch;
    if (in_num) begin
      byte_sel = tsv_pkg::ChTab;
      for (int i = 0; i < Nd; i++) begin
        if (idx_q == tsv_pkg::IdxW'(Nd - 1 - i)) begin
          byte_sel = blank[i] ? tsv_pkg::ChSpace : {tsv_pkg::ChDigitHi, head_i.bcd[4*i +: 4]};
        end
      end
    end else if (k < pre_len) begin
      case (head_i.pre)
        tsv_pkg::PRE_DOLLAR: byte_sel = tsv_pkg::ChDollar;
        tsv_pkg::PRE_META: begin
          if (k == tsv_pkg::IdxW'(0))      byte_sel = tsv_pkg::ChM;
          else if (k == tsv_pkg::IdxW'(1)) byte_sel = tsv_pkg::ChMinus;
          else                             byte_sel = tsv_pkg::ChCaret;
        end
        default: byte_sel = tsv_pkg::ChCaret;
      endcase
    end
  end

  assign out_valid_o            = !empty_i;
  assign out_data_o.out_byte    = byte_sel;
  assign out_data_o.last_of_run = last;
  assign pop_o                  = out_valid_o && !out_stall_i && last;

  always_comb begin
    idx_d = idx_q;
    if (out_valid_o && !out_stall_i) idx_d = last ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else         idx_q <= idx_d;
  end

endmodule

>>> sv/text_stream_visualizer.sv
// Text stream visualiser top level: config registers, front end, descriptor queue, back end.
// An accepted byte's run descriptor is registered in the queue; its bytes show once it reaches the head.
// Throughput: one input byte per cycle while runs are one byte and the output does not stall; a run
//   of N (up to 11) bytes takes N output transactions; input stalls only when the 4-entry queue is full.
// Reset (rst_ni, async, active low): registers to 0, line count 0, start-of-line set, queue empty.
// Depends on tsv_pkg, tsv_front, tsv_queue and tsv_back.
module text_stream_visualizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [tsv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tsv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input bytes
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tsv_pkg::in_t                  in_data_i,
  // formatted output bytes
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tsv_pkg::out_t                 out_data_o
);

  tsv_pkg::cfg_t  cfg_q, cfg_d;
  tsv_pkg::push_t push;
  tsv_pkg::desc_t head;
  logic           q_full, q_empty, pop;

  // The user must write config only while idle (not enforced by the block), so front end reads it directly.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tsv_pkg::REG_NUMBER_MODE:      cfg_d.number_mode      = cfg_wdata_i[1:0];
        tsv_pkg::REG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = cfg_wdata_i[0];
        tsv_pkg::REG_SHOW_ENDS:        cfg_d.show_ends        = cfg_wdata_i[0];
        tsv_pkg::REG_SHOW_TABS:        cfg_d.show_tabs        = cfg_wdata_i[0];
        tsv_pkg::REG_SHOW_NONPRINTING: cfg_d.show_nonprinting = cfg_wdata_i[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= '0;
    else         cfg_q <= cfg_d;
  end

  // front: classify each byte, update line state, queue a run descriptor
  tsv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push)
  );

  // queue decouples the two sides; a squeezed newline queues nothing
  tsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // back: expand the head descriptor, one byte per output transaction
  tsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/tsv_checker.sv
// Port-level checker for the text stream visualiser, bound to the top level.
// Depends on tsv_pkg and text_stream_visualizer_assert.svh.
`include "text_stream_visualizer_assert.svh"

module tsv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [tsv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [tsv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input tsv_pkg::in_t                  in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input tsv_pkg::out_t                 out_data_o
);

  // stalled output transaction holds
  `TSV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // input only stalls when queued runs are waiting at the output
  `TSV_ASSERT_NOW(a_stall_has_work, in_stall_o, out_valid_o)

  // a run that is not finished keeps the output valid
  `TSV_ASSERT_NEXT(a_run_continues, out_valid_o && !out_data_o.last_of_run, out_valid_o)

endmodule

bind text_stream_visualizer tsv_checker u_tsv_checker (.*);

>>> verif/text_stream_visualizer_tb.sv
// Self-checking testbench for text_stream_visualizer: a short directed sequence, then
// random text bytes under several register settings and handshake idling patterns.
// Depends on tsv_pkg and the text_stream_visualizer RTL.
module text_stream_visualizer_tb;
  import tsv_pkg::*;

  // numbering codes not named in the package
  localparam logic [1:0] NumOff       = 2'd0;
  localparam logic [1:0] NumUndefined = 2'd3;

  localparam int Phases       = 8;
  localparam int PhaseItems   = 46;
  // a run is at most 11 bytes, the queue 4 deep; the settle time covers a squeezed byte in flight
  localparam int SettleCycles = 16;
  // quiet cycles tolerated before the run is declared hung
  localparam int QuietLimit   = 4000;

  // Tracks the per-file line state and register settings, and keeps the formatted bytes
  // still owed by the block in arrival order.
  class byte_run_scoreboard;
    cfg_t            mode;
    logic [BcdW-1:0] line_bcd;
    logic            at_line_start;
    logic [1:0]      nl_streak;
    out_t            pending_bytes[$];
    int unsigned     errors;
    int unsigned     bytes_in;
    int unsigned     bytes_out;
    int unsigned     squeezed;

    function new();
      mode          = '0;
      line_bcd      = '0;
      at_line_start = 1'b1;
      nl_streak     = '0;
      errors        = 0;
      bytes_in      = 0;
      bytes_out     = 0;
      squeezed      = 0;
    endfunction

    // only the low bits of each register are kept
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_NUMBER_MODE:      mode.number_mode      = data[1:0];
        REG_SQUEEZE_BLANK:    mode.squeeze_blank    = data[0];
        REG_SHOW_ENDS:        mode.show_ends        = data[0];
        REG_SHOW_TABS:        mode.show_tabs        = data[0];
        REG_SHOW_NONPRINTING: mode.show_nonprinting = data[0];
        default: ;
      endcase
    endfunction

    // works out the formatted run for one accepted byte
    function void note_byte(in_t item);
      logic [7:0] c;
      logic       is_nl;
      logic       leading;
      logic       full;
      logic [3:0] d;
      logic [7:0] run[$];
      bytes_in++;
      c     = item.in_byte;
      is_nl = (c == ChNl);
      if (item.start_of_file) begin
        line_bcd      = '0;
        at_line_start = 1'b1;
        nl_streak     = '0;
      end
      // third newline in a row is dropped, state untouched
      if (mode.squeeze_blank && is_nl && nl_streak == 2'd2) begin
        squeezed++;
        return;
      end
      if (at_line_start &&
          (mode.number_mode == NUM_ALL || (mode.number_mode == NUM_NONEMPTY && !is_nl))) begin
        // decimal count, holding at all nines
        full = 1'b1;
        for (int i = 0; i < NumberDigits; i++)
          if (line_bcd[4*i +: 4] != 4'd9) full = 1'b0;
        if (!full) begin
          for (int i = 0; i < NumberDigits; i++) begin
            d = line_bcd[4*i +: 4];
            if (d == 4'd9) begin
              line_bcd[4*i +: 4] = 4'd0;
            end else begin
              line_bcd[4*i +: 4] = d + 4'd1;
              break;
            end
          end
        end
        // right-aligned, space padded, then a tab
        leading = 1'b1;
        for (int i = NumberDigits - 1; i >= 0; i--) begin
          d = line_bcd[4*i +: 4];
          if (leading && d == 4'd0 && i > 0) begin
            run.push_back(ChSpace);
          end else begin
            leading = 1'b0;
            run.push_back({ChDigitHi, d});
          end
        end
        run.push_back(ChTab);
      end
      if (mode.show_tabs && c == ChTab) begin
        run.push_back(ChCaret);
        c = ChI;
      end
      if (is_nl) begin
        if (nl_streak != 2'd3) nl_streak++;
        if (mode.show_ends) run.push_back(ChDollar);
      end else begin
        nl_streak = '0;
      end
      if (mode.show_nonprinting && c != ChNl && c != ChTab) begin
        if (c >= ChMetaLo && c <= ChMetaHi) begin
          run.push_back(ChM);
          run.push_back(ChMinus);
          run.push_back(ChCaret);
          c = c - ChShift;
        end else if (c <= ChCtlHi) begin
          run.push_back(ChCaret);
          c = c + ChShift;
        end else if (c == ChDel) begin
          run.push_back(ChCaret);
          c = ChQuest;
        end
      end
      run.push_back(c);
      at_line_start = is_nl;
      foreach (run[i])
        pending_bytes.push_back('{out_byte: run[i], last_of_run: (i == run.size() - 1)});
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      // keep the log short if everything goes wrong
      if (errors <= 40)
        $display("mismatch: %s got %0h want %0h at output byte %0d", what, got, want,
                 bytes_out);
    endtask

    task check_byte(out_t got);
      out_t want;
      bytes_out++;
      if (pending_bytes.size() == 0) begin
        report("byte with nothing owed", 32'(got.out_byte), 0);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  byte_run_scoreboard sb = new();

  int          sender_idle_pct   = 0;
  int          receiver_idle_pct = 0;
  int unsigned settings_loaded   = 0;
  int unsigned quiet_cycles      = 0;

  text_stream_visualizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // output side stalls at random, re-rolled every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Monitor: everything is sampled at the rising edge, so the values seen are the ones
  // the block saw. Register writes go to the model as they happen; accepted input bytes
  // queue their expected run; accepted output bytes are checked against it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_byte(out_data_o);
      // watchdog: any transaction or register write counts as progress
      if (cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d bytes still owed",
                 QuietLimit, sb.pending_bytes.size());
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_t make_item(logic [7:0] b, logic sof);
    in_t it;
    it.in_byte       = b;
    it.start_of_file = sof;
    return it;
  endfunction

  // mostly printable text and newlines, some tabs, control and high bytes, rare file starts
  function automatic in_t random_text_byte();
    in_t         it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      it.in_byte = 8'($urandom_range(32, 126));
    else if (r < 64) it.in_byte = ChNl;
    else if (r < 70) it.in_byte = ChTab;
    else if (r < 78) it.in_byte = 8'($urandom_range(0, 31));
    else if (r < 86) it.in_byte = 8'($urandom_range(127, 159));
    else if (r < 94) it.in_byte = 8'($urandom_range(160, 255));
    else             it.in_byte = 8'($urandom_range(0, 255));
    it.start_of_file = ($urandom_range(0, 59) == 0);
    return it;
  endfunction

  // Holds valid with a steady payload until the transaction goes through; returns just
  // after the accepting edge, leaving valid high for whoever drives next.
  task automatic send_byte(input in_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // one-bit registers get random upper data bits, which the block must ignore
  task automatic write_flag(input logic [CfgIdxW-1:0] idx, input logic val);
    logic [CfgDataW-1:0] word;
    word        = CfgDataW'($urandom_range(0, 3));
    word[0]     = val;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= word;
    @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic load_settings(input cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_NUMBER_MODE;
    cfg_wdata_i <= c.number_mode;
    @(posedge clk_i);
    write_flag(REG_SQUEEZE_BLANK, c.squeeze_blank);
    write_flag(REG_SHOW_ENDS, c.show_ends);
    write_flag(REG_SHOW_TABS, c.show_tabs);
    write_flag(REG_SHOW_NONPRINTING, c.show_nonprinting);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // a squeezed newline leaves nothing to wait for, hence the settle time after the drain
  task automatic wait_drain();
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    cfg_t settings;
    int   sent;
    int   burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every display mode on, so each byte class shows its notation. Covers a
    // tab under both tab and control display, squeezed newlines (twice in a row), the
    // control, DEL and meta boundaries, pass-through bytes and a file start on a newline.
    settings = '{number_mode: NUM_ALL, squeeze_blank: 1'b1, show_ends: 1'b1,
                 show_tabs: 1'b1, show_nonprinting: 1'b1};
    load_settings(settings);
    send_byte(make_item(8'h41, 1'b1));
    send_byte(make_item(ChTab, 1'b0));
    send_byte(make_item(ChNl, 1'b0));
    send_byte(make_item(ChNl, 1'b0));
    send_byte(make_item(ChNl, 1'b0));
    send_byte(make_item(ChNl, 1'b0));
    send_byte(make_item(8'h00, 1'b0));
    send_byte(make_item(ChCtlHi, 1'b0));
    send_byte(make_item(ChSpace, 1'b0));
    send_byte(make_item(8'h7E, 1'b0));
    send_byte(make_item(ChDel, 1'b0));
    send_byte(make_item(ChMetaLo, 1'b0));
    send_byte(make_item(ChMetaHi, 1'b0));
    send_byte(make_item(8'hA0, 1'b0));
    send_byte(make_item(8'hFF, 1'b0));
    send_byte(make_item(ChNl, 1'b0));
    send_byte(make_item(ChNl, 1'b1));
    send_byte(make_item(8'h0D, 1'b0));
    send_byte(make_item(ChNl, 1'b0));
    send_byte(make_item(8'h1B, 1'b0));
    in_valid_i <= 1'b0;
    wait_drain();

    // Random phases: fixed extremes first, then random settings; idling rotates through
    // none, sender only, receiver only and both.
    for (int p = 1; p <= Phases; p++) begin
      case (p)
        1: settings = '0;
        2: settings = '{number_mode: NUM_NONEMPTY, squeeze_blank: 1'b1, show_ends: 1'b0,
                        show_tabs: 1'b0, show_nonprinting: 1'b0};
        3: settings = '{number_mode: NumUndefined, squeeze_blank: 1'b1, show_ends: 1'b1,
                        show_tabs: 1'b1, show_nonprinting: 1'b1};
        4: settings = '{number_mode: NUM_ALL, squeeze_blank: 1'b1, show_ends: 1'b1,
                        show_tabs: 1'b1, show_nonprinting: 1'b1};
        5: settings = '{number_mode: NumOff, squeeze_blank: 1'b0, show_ends: 1'b0,
                        show_tabs: 1'b1, show_nonprinting: 1'b1};
        default: settings = 6'($urandom_range(0, 63));
      endcase
      load_settings(settings);
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
        1: begin sender_idle_pct = 54; receiver_idle_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_idle_pct = 54; end
        default: begin sender_idle_pct = 10; receiver_idle_pct = 10; end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        // runs of blank lines so squeezing and non-empty numbering get exercised
        if ($urandom_range(0, 19) == 0) begin
          burst = $urandom_range(2, 4);
          repeat (burst) begin
            send_byte(make_item(ChNl, 1'b0));
            sent++;
          end
        end else begin
          send_byte(random_text_byte());
          sent++;
        end
      end
      in_valid_i <= 1'b0;
      wait_drain();
    end

    if (sb.pending_bytes.size() != 0)
      sb.report("bytes never delivered", sb.pending_bytes.size(), 0);
    $display("run: %0d input bytes over %0d register settings, %0d newlines squeezed",
             sb.bytes_in, settings_loaded, sb.squeezed);
    $display("run: %0d formatted bytes checked, %0d mismatches", sb.bytes_out, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/tsv_pkg.sv
sv/tsv_front.sv
sv/tsv_queue.sv
sv/tsv_back.sv
sv/text_stream_visualizer.sv
sv/tsv_checker.sv
verif/text_stream_visualizer_tb.sv
